>>> sv/lruk_pkg.sv
// Package for the LRU-K frame replacer: sizes, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lruk_pkg;
  localparam int NumFrames = 64;
  localparam int KMax      = 4;
  localparam int FrameW    = $clog2(NumFrames);
  localparam int KW        = $clog2(KMax + 1);
  localparam int SlotW     = (KMax > 1) ? $clog2(KMax) : 1;
  localparam int HistDepth = NumFrames * KMax;
  localparam int HistAw    = $clog2(HistDepth);
  localparam int CountW    = $clog2(NumFrames + 1);
  localparam int TickW     = 48;

  localparam logic [1:0] ModeAccess = 2'd0;
  localparam logic [1:0] ModeSetEv  = 2'd1;
  localparam logic [1:0] ModeRemove = 2'd2;
  localparam logic [1:0] ModeEvict  = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StRange    = 2'd1;
  localparam logic [1:0] StPinned   = 2'd2;
  localparam logic [1:0] StNoVictim = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture request
    logic apply;     // perform access/set/remove update
    logic scan_rd;   // issue metadata read for idx_q
    logic scan_clr;  // reset the scan best registers
    logic evict;     // retire the chosen victim
    logic done;      // present the result
  } ctrl_t;

  typedef struct packed {
    logic last_idx;  // scan index at final frame
  } stat_t;
endpackage
`default_nettype wire

>>> sv/lruk_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lruk_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> sv/lruk_datapath.sv
// Datapath: per-frame flags, metadata and history RAMs, tick and victim search.
// Depends on lruk_pkg and lruk_ram.
`timescale 1ns / 1ps
`default_nettype none
module lruk_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire lruk_pkg::ctrl_t           ctrl_i,
  output lruk_pkg::stat_t                stat_o,
  input  wire logic [1:0]                mode_i,
  input  wire logic [5:0]                frame_id_i,
  input  wire logic                      make_evictable_i,
  input  wire logic                      k_we_i,
  input  wire logic [2:0]                k_wdata_i,
  output logic                           victim_valid_o,
  output logic [5:0]                     victim_frame_o,
  output logic [1:0]                     status_o,
  output logic [6:0]                     evictable_count_o,
  output logic                           done_o
);
  import lruk_pkg::*;

  logic [NumFrames-1:0] tracked_q, evict_q;
  logic [TickW-1:0]     tick_q;
  logic [CountW-1:0]    total_q;
  logic [2:0]           k_q;

  logic [1:0]           mode_q;
  logic [5:0]           fid_q;
  logic                 mk_q;

  logic [FrameW-1:0]    idx_q, m_idx_q, cmp_idx_q;
  logic                 m_ok_q;
  logic                 cmp_ok_q, cmp_inf_q;
  logic                 inf_found_q, fin_found_q;
  logic [TickW-1:0]     inf_key_q, fin_key_q;
  logic [FrameW-1:0]    inf_best_q, fin_best_q;

  logic [KW-1:0]        keff;
  logic [FrameW-1:0]    f;
  logic                 in_range;
  logic [SlotW-1:0]     rd_slot;
  logic [KW-1:0]        back;
  logic                 cur_inf;
  logic [TickW-1:0]     rkey;
  logic                 ram_we;
  logic [HistAw-1:0]    waddr, raddr;

  logic [KW+SlotW-1:0]  meta_rd, meta_wd;
  logic [FrameW-1:0]    meta_raddr;
  logic [KW-1:0]        m_cnt, cur_cnt, new_cnt;
  logic [SlotW-1:0]     m_head, cur_head, new_head;

  // clamp k into 1..KMax
  always_comb begin
    if (k_q == 3'd0) keff = KW'(1);
    else if (32'(k_q) > KMax) keff = KW'(KMax);
    else keff = KW'(k_q);
  end

  assign f        = fid_q[FrameW-1:0];
  assign in_range = (32'(fid_q) < NumFrames);

  // metadata word {count, head}; an untracked frame reads as all zero
  assign m_cnt    = meta_rd[KW+SlotW-1:SlotW];
  assign m_head   = meta_rd[SlotW-1:0];
  assign cur_cnt  = tracked_q[f] ? m_cnt : '0;
  assign cur_head = tracked_q[f] ? m_head : '0;
  assign new_head = SlotW'((32'(cur_head) + 1) % KMax);
  assign new_cnt  = (32'(cur_cnt) < KMax) ? cur_cnt + KW'(1) : cur_cnt;
  assign meta_wd  = {new_cnt, new_head};
  assign meta_raddr = ctrl_i.load ? frame_id_i[FrameW-1:0] : idx_q;

  // scan stage two: metadata of m_idx_q is on meta_rd
  assign cur_inf  = (m_cnt < keff);
  assign back     = cur_inf ? m_cnt : keff;
  assign rd_slot  = SlotW'((32'(m_head) + KMax - 32'(back)) % KMax);
  assign raddr    = HistAw'(32'(m_idx_q) * KMax + 32'(rd_slot));
  assign ram_we   = ctrl_i.apply && mode_q == ModeAccess && in_range;
  assign waddr    = HistAw'(32'(f) * KMax + 32'(cur_head));
  assign stat_o.last_idx = (32'(idx_q) == NumFrames - 1);

  lruk_ram #(.Width(TickW), .Depth(HistDepth)) u_hist (
    .clk_i, .we_i(ram_we), .waddr_i(waddr), .wdata_i(tick_q),
    .raddr_i(raddr), .rdata_o(rkey)
  );

  lruk_ram #(.Width(KW + SlotW), .Depth(NumFrames)) u_meta (
    .clk_i, .we_i(ram_we), .waddr_i(f), .wdata_i(meta_wd),
    .raddr_i(meta_raddr), .rdata_o(meta_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_q <= '0;
      evict_q   <= '0;
      tick_q      <= '0;
      total_q     <= '0;
      k_q         <= 3'd2;
      done_o      <= 1'b0;
      idx_q       <= '0;
      m_ok_q      <= 1'b0;
      cmp_ok_q    <= 1'b0;
      inf_found_q <= 1'b0;
      fin_found_q <= 1'b0;
      victim_valid_o <= 1'b0;
      victim_frame_o <= '0;
      status_o       <= StOk;
    end else begin
      done_o   <= ctrl_i.done;
      if (k_we_i) k_q <= k_wdata_i;
      if (ctrl_i.load) begin
        mode_q <= mode_i;
        fid_q  <= frame_id_i;
        mk_q   <= make_evictable_i;
        victim_valid_o <= 1'b0;
        victim_frame_o <= '0;
        status_o       <= StOk;
      end
      if (ctrl_i.apply) begin
        if (!in_range) status_o <= StRange;
        else unique case (mode_q)
          ModeAccess: begin
            tracked_q[f] <= 1'b1;
            if (!tracked_q[f]) evict_q[f] <= 1'b0;
            tick_q <= tick_q + TickW'(1);
          end
          ModeSetEv: if (tracked_q[f]) begin
            if (!evict_q[f] && mk_q) total_q <= total_q + CountW'(1);
            else if (evict_q[f] && !mk_q) total_q <= total_q - CountW'(1);
            evict_q[f] <= mk_q;
          end
          ModeRemove: if (tracked_q[f]) begin
            if (!evict_q[f]) status_o <= StPinned;
            else begin
              tracked_q[f] <= 1'b0;
              evict_q[f]   <= 1'b0;
              total_q      <= total_q - CountW'(1);
            end
          end
          default: ;
        endcase
      end
      if (ctrl_i.scan_clr) begin
        idx_q       <= '0;
        inf_found_q <= 1'b0;
        fin_found_q <= 1'b0;
      end
      // stage one: read metadata of idx_q
      m_ok_q <= ctrl_i.scan_rd && tracked_q[idx_q] && evict_q[idx_q];
      if (ctrl_i.scan_rd) begin
        m_idx_q <= idx_q;
        if (!stat_o.last_idx) idx_q <= idx_q + FrameW'(1);
      end
      // stage two: read the key from history
      cmp_ok_q  <= m_ok_q;
      cmp_inf_q <= cur_inf;
      cmp_idx_q <= m_idx_q;
      // stage three: compare (strict less: lowest index wins)
      if (cmp_ok_q) begin
        if (cmp_inf_q) begin
          if (!inf_found_q || rkey < inf_key_q) begin
            inf_found_q <= 1'b1; inf_key_q <= rkey; inf_best_q <= cmp_idx_q;
          end
        end else if (!fin_found_q || rkey < fin_key_q) begin
          fin_found_q <= 1'b1; fin_key_q <= rkey; fin_best_q <= cmp_idx_q;
        end
      end
      if (ctrl_i.evict) begin
        if (inf_found_q || fin_found_q) begin
          logic [FrameW-1:0] v;
          v = inf_found_q ? inf_best_q : fin_best_q;
          tracked_q[v] <= 1'b0;
          evict_q[v]   <= 1'b0;
          total_q      <= total_q - CountW'(1);
          victim_valid_o <= 1'b1;
          victim_frame_o <= 6'(v);
        end else status_o <= StNoVictim;
      end
    end
  end

  assign evictable_count_o = 7'(total_q);
endmodule
`default_nettype wire

>>> sv/lruk_ctrl.sv
// Controller state machine for the LRU-K frame replacer.
// Depends on lruk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lruk_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [1:0]      mode_i,
  input  wire lruk_pkg::stat_t stat_i,
  output lruk_pkg::ctrl_t      ctrl_o,
  output logic                 busy_o
);
  import lruk_pkg::*;

  typedef enum logic [2:0] {SIdle, SApply, SScan, SDrain, SWait, SEvict, SDone} state_e;
  state_e state_q;

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.load     = start_i && !busy_o;
    ctrl_o.scan_clr = ctrl_o.load;
    unique case (state_q)
      SApply: ctrl_o.apply = 1'b1;
      SScan:  begin ctrl_o.scan_rd = 1'b1; end
      SEvict: ctrl_o.evict = 1'b1;
      SDone:  ctrl_o.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      busy_o  <= 1'b0;
    end else begin
      unique case (state_q)
        SIdle: if (start_i) begin
          state_q <= (mode_i == ModeEvict) ? SScan : SApply;
          busy_o  <= 1'b1;
        end
        SApply: state_q <= SDone;
        SScan:  if (stat_i.last_idx) state_q <= SDrain;
        SDrain: state_q <= SWait;
        SWait:  state_q <= SEvict;
        SEvict: state_q <= SDone;
        SDone: begin
          state_q <= SIdle;
          busy_o  <= 1'b0;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sv/lru_k_frame_replacer.sv
// Top level of the LRU-K frame replacer: controller plus datapath.
// Depends on lruk_pkg, lruk_ctrl, lruk_datapath.
//
// Usage: raise start with mode_i, frame_id_i and make_evictable_i; the
// request transaction is accepted at a clock edge where start is high and
// busy is low. busy then stays high until the result is shown.
// One result per request: done_o is high for exactly one cycle together
// with victim_valid_o, victim_frame_o, status_o and evictable_count_o.
// The receiver cannot stall; the result must be taken in that cycle.
// Steps, from the accepting edge to the edge that takes the result:
// access, set-evictable and remove do a metadata read, the update and the
// result; evict scans the frames, reading one frame's metadata per cycle,
// then its key from the history RAM, then comparing it, and then retires the
// victim. busy is already low in the done_o cycle, so the next request
// can be accepted at the edge that ends it. k_value is written with
// k_we_i/k_value_i, reset value 2; the user must write it only while idle,
// as the block does not enforce this.
// Reset (rst_ni low) clears all frames, the tick and the count at once.
`timescale 1ns / 1ps
`default_nettype none
module lru_k_frame_replacer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] mode_i,
  input  wire logic [5:0] frame_id_i,
  input  wire logic       make_evictable_i,
  input  wire logic       k_we_i,
  input  wire logic [2:0] k_value_i,
  output logic            done_o,
  output logic            victim_valid_o,
  output logic [5:0]      victim_frame_o,
  output logic [1:0]      status_o,
  output logic [6:0]      evictable_count_o
);
  import lruk_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  lruk_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .mode_i, .stat_i(stat),
    .ctrl_o(ctrl), .busy_o(busy)
  );

  lruk_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .mode_i, .frame_id_i,
    .make_evictable_i, .k_we_i, .k_wdata_i(k_value_i),
    .victim_valid_o, .victim_frame_o, .status_o, .evictable_count_o, .done_o
  );
endmodule
`default_nettype wire

>>> sv/lruk_checker.sv
// Port-level checker for the LRU-K frame replacer, bound to the top level.
// Depends on lruk_pkg and lru_k_frame_replacer.
`timescale 1ns / 1ps
`default_nettype none
module lruk_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done_o,
  input wire logic       victim_valid_o,
  input wire logic [5:0] victim_frame_o,
  input wire logic [1:0] status_o,
  input wire logic [6:0] evictable_count_o
);
  import lruk_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised");
  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy held during done");
  a_victim_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && victim_valid_o |-> status_o == StOk) else $error("victim with bad status");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evictable_count_o <= 7'd64) else $error("count out of range");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");
endmodule

bind lru_k_frame_replacer lruk_checker u_chk (.*);
`default_nettype wire

>>> verif/tb_lru_k_frame_replacer.sv
// Self-checking testbench for lru_k_frame_replacer: a queue-fed request driver,
// a result monitor and an in-bench LRU-K predictor. Depends on lruk_pkg.
`timescale 1ns / 1ps
module tb_lru_k_frame_replacer;
  import lruk_pkg::*;

  localparam int KindReq   = 0;
  localparam int KindCfg   = 1;
  localparam int KindDrain = 2;
  localparam int CycleLimit = 2000000;

  typedef struct {
    int         kind;
    logic [1:0] mode;
    logic [5:0] fid;
    logic       mk;
    logic [2:0] kv;
  } pending_t;

  typedef struct {
    logic       vvalid;
    logic [5:0] vframe;
    logic [1:0] status;
    logic [6:0] count;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] mode_i = '0;
  logic [5:0] frame_id_i = '0;
  logic make_evictable_i = 1'b0;
  logic k_we_i = 1'b0;
  logic [2:0] k_value_i = '0;
  logic done_o, victim_valid_o;
  logic [5:0] victim_frame_o;
  logic [1:0] status_o;
  logic [6:0] evictable_count_o;

  lru_k_frame_replacer uut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .frame_id_i, .make_evictable_i,
    .k_we_i, .k_value_i, .done_o, .victim_valid_o, .victim_frame_o,
    .status_o, .evictable_count_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic        trk[NumFrames];
  logic        evb[NumFrames];
  int unsigned acc_cnt[NumFrames];
  int unsigned head[NumFrames];
  logic [47:0] stamps[NumFrames][KMax];
  logic [47:0] tick = '0;
  int unsigned ev_total = 0;
  logic [2:0]  k_reg = 3'd2;

  pending_t pending_q[$];
  outcome_t outcome_q[$];
  int fails = 0;
  int issued = 0;
  int cycles = 0;
  bit stim_done = 0;

  initial begin
    for (int f = 0; f < NumFrames; f++) begin
      trk[f] = 0; evb[f] = 0; acc_cnt[f] = 0; head[f] = 0;
      for (int s = 0; s < KMax; s++) stamps[f][s] = '0;
    end
  end

  task automatic predict_lru_k(input logic [1:0] mode, input logic [5:0] fid, input logic mk,
                               output outcome_t o);
    int unsigned k;
    int unsigned back;
    bit found_inf, found_fin;
    int best_inf, best_fin;
    logic [47:0] key, key_inf, key_fin;
    int v;
    k = (k_reg == 0) ? 1 : ((k_reg > KMax) ? KMax : k_reg);
    o = '{1'b0, 6'd0, StOk, 7'd0};
    found_inf = 0; found_fin = 0; best_inf = 0; best_fin = 0;
    key_inf = '0; key_fin = '0;
    case (mode)
      ModeAccess: begin
        if (!trk[fid]) begin
          trk[fid] = 1; evb[fid] = 0; acc_cnt[fid] = 0; head[fid] = 0;
        end
        stamps[fid][head[fid]] = tick;
        head[fid] = (head[fid] + 1) % KMax;
        if (acc_cnt[fid] < KMax) acc_cnt[fid]++;
        tick = tick + 48'd1;
      end
      ModeSetEv: begin
        if (trk[fid]) begin
          if (!evb[fid] && mk) ev_total++;
          else if (evb[fid] && !mk) ev_total--;
          evb[fid] = mk;
        end
      end
      ModeRemove: begin
        if (trk[fid]) begin
          if (!evb[fid]) o.status = StPinned;
          else begin
            trk[fid] = 0; evb[fid] = 0; acc_cnt[fid] = 0; head[fid] = 0;
            ev_total--;
          end
        end
      end
      default: begin
        for (int f = 0; f < NumFrames; f++) begin
          if (trk[f] && evb[f]) begin
            back = (acc_cnt[f] < k) ? acc_cnt[f] : k;
            key = stamps[f][(head[f] + KMax - back) % KMax];
            if (acc_cnt[f] < k) begin
              if (!found_inf || key < key_inf) begin
                found_inf = 1; key_inf = key; best_inf = f;
              end
            end else if (!found_fin || key < key_fin) begin
              found_fin = 1; key_fin = key; best_fin = f;
            end
          end
        end
        if (found_inf || found_fin) begin
          v = found_inf ? best_inf : best_fin;
          trk[v] = 0; evb[v] = 0; acc_cnt[v] = 0; head[v] = 0;
          ev_total--;
          o.vvalid = 1'b1;
          o.vframe = v[5:0];
        end else begin
          o.status = StNoVictim;
        end
      end
    endcase
    o.count = ev_total[6:0];
  endtask

  function automatic pending_t req(input logic [1:0] mode, input int fid, input logic mk);
    pending_t p;
    p = '{KindReq, mode, fid[5:0], mk, 3'd0};
    return p;
  endfunction

  function automatic pending_t cfg(input int kv);
    pending_t p;
    p = '{KindCfg, ModeAccess, 6'd0, 1'b0, kv[2:0]};
    return p;
  endfunction

  task automatic enqueue(input pending_t p);
    pending_q = {pending_q, p};
  endtask

  function automatic int pick_frame();
    // mostly a hot set so frames collect history; sometimes any frame
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, 7) + 8 * $urandom_range(0, 1) * 7;
  endfunction

  // stimulus
  initial begin
    int k_plan[6] = '{2, 1, 4, 0, 7, 3};
    int n, f;
    enqueue(req(ModeEvict, 0, 1'b0));
    enqueue(req(ModeAccess, 0, 1'b0));
    enqueue(req(ModeAccess, 63, 1'b1));
    enqueue(req(ModeSetEv, 63, 1'b1));
    enqueue(req(ModeRemove, 0, 1'b0));
    enqueue(req(ModeRemove, 5, 1'b1));
    enqueue(req(ModeSetEv, 5, 1'b1));
    enqueue(req(ModeSetEv, 0, 1'b1));
    enqueue(req(ModeSetEv, 0, 1'b0));
    enqueue(req(ModeSetEv, 0, 1'b1));
    enqueue(req(ModeSetEv, 0, 1'b1));
    enqueue(req(ModeAccess, 63, 1'b0));
    enqueue(req(ModeAccess, 42, 1'b0));
    enqueue(req(ModeAccess, 21, 1'b0));
    enqueue(req(ModeSetEv, 42, 1'b1));
    enqueue(req(ModeSetEv, 21, 1'b1));
    enqueue(req(ModeEvict, 63, 1'b1));
    enqueue(req(ModeEvict, 0, 1'b0));
    enqueue(req(ModeRemove, 21, 1'b0));
    enqueue(req(ModeEvict, 0, 1'b0));
    enqueue(req(ModeEvict, 0, 1'b0));
    for (int ph = 0; ph < 6; ph++) begin
      enqueue(cfg(k_plan[ph]));
      n = 0;
      while (n < 190) begin
        if (ph == 2 && n > 90 && n < 100) enqueue('{KindDrain, 2'd0, 6'd0, 1'b0, 3'd0});
        if ($urandom_range(0, 99) < 70) begin
          // well-formed: touch a few frames, mostly make them evictable, then evict
          for (int j = $urandom_range(1, 4); j > 0; j--) begin
            f = pick_frame();
            for (int a = $urandom_range(1, 5); a > 0; a--) begin
              enqueue(req(ModeAccess, f, 1'($urandom_range(0, 1))));
              n++;
            end
            enqueue(req(ModeSetEv, f, $urandom_range(0, 5) != 0));
            n++;
          end
          for (int e = $urandom_range(0, 2); e > 0; e--) begin
            enqueue(req(ModeEvict, $urandom_range(0, 63), 1'($urandom_range(0, 1))));
            n++;
          end
        end else begin
          enqueue(req(2'($urandom_range(0, 3)), pick_frame(), 1'($urandom_range(0, 1))));
          n++;
        end
      end
    end
    stim_done = 1;
  end

  // driver
  always @(posedge clk_i) begin
    outcome_t o;
    bit taken;
    if (rst_ni) begin
      taken = start && !busy;
      if (taken) begin
        predict_lru_k(mode_i, frame_id_i, make_evictable_i, o);
        outcome_q = {outcome_q, o};
      end
      k_we_i <= 1'b0;
      if (start && !taken) begin
        // hold the request until it is accepted
      end else if (pending_q.size() == 0) begin
        start <= 1'b0;
      end else if (pending_q[0].kind != KindReq) begin
        start <= 1'b0;
        if (!taken && !start && !busy && outcome_q.size() == 0) begin
          if (pending_q[0].kind == KindCfg) begin
            k_we_i <= 1'b1;
            k_value_i <= pending_q[0].kv;
            k_reg = pending_q[0].kv;
          end
          pending_q.delete(0);
        end
      end else if ((issued < 400 || issued > 560) && $urandom_range(0, 99) < 32) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        mode_i <= pending_q[0].mode;
        frame_id_i <= pending_q[0].fid;
        make_evictable_i <= pending_q[0].mk;
        pending_q.delete(0);
        issued++;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        $error("unexpected result transaction");
        fails++;
      end else begin
        e = outcome_q[0];
        outcome_q.delete(0);
        if (victim_valid_o !== e.vvalid) begin
          $error("victim_valid expected %0d actual %0d", e.vvalid, victim_valid_o);
          fails++;
        end
        if (victim_frame_o !== e.vframe) begin
          $error("victim_frame expected %0d actual %0d", e.vframe, victim_frame_o);
          fails++;
        end
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o);
          fails++;
        end
        if (evictable_count_o !== e.count) begin
          $error("evictable_count expected %0d actual %0d", e.count, evictable_count_o);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("lru_k_frame_replacer regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && pending_q.size() == 0 && !start);
    wait (outcome_q.size() == 0);
    repeat (80) @(posedge clk_i);
    if (fails == 0 && outcome_q.size() == 0) begin
      $display("lru_k_frame_replacer regression: pass");
    end else begin
      $display("lru_k_frame_replacer regression: fail");
    end
    $finish;
  end
endmodule

>>> lru_k_frame_replacer.f
sv/lruk_pkg.sv
sv/lruk_ram.sv
sv/lruk_datapath.sv
sv/lruk_ctrl.sv
sv/lru_k_frame_replacer.sv
sv/lruk_checker.sv
verif/tb_lru_k_frame_replacer.sv
